FILE: rtl/srl_pkg.sv
// Package for the sequential record list: sizes, codes and record types.
// Used by the interfaces, the controller, the top level and the checker.
package srl_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W   = 64;
  localparam int NAME_W  = 64;
  localparam int SCORE_W = 10;
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  typedef enum logic [1:0] {
    KIND_APPEND   = 2'd0,
    KIND_DEL_HEAD = 2'd1,
    KIND_SEARCH   = 2'd2,
    KIND_DEL_KEY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] entry_total;
  } res_t;

endpackage

FILE: rtl/srl_if.sv
// Valid/ready channel interfaces for the sequential record list.
// Depends on srl_pkg.
interface srl_in_if;
  logic                          valid;
  logic                          ready;
  srl_pkg::kind_t                kind;
  logic [srl_pkg::KEY_W-1:0]     rec_key;
  logic [srl_pkg::NAME_W-1:0]    rec_name;
  logic [srl_pkg::SCORE_W-1:0]   rec_score;

  modport source (output valid, kind, rec_key, rec_name, rec_score, input ready);
  modport sink (input valid, kind, rec_key, rec_name, rec_score, output ready);
endinterface

interface srl_out_if;
  logic                        valid;
  logic                        ready;
  srl_pkg::status_t            status;
  logic [srl_pkg::CNT_W-1:0]   position;
  logic [srl_pkg::CNT_W-1:0]   entry_total;

  modport source (output valid, status, position, entry_total, input ready);
  modport sink (input valid, status, position, entry_total, output ready);
endinterface

FILE: rtl/srl_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module srl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/srl_ctrl.sv
// Command sequencer: scans and shifts the record memory one entry a cycle.
// Depends on srl_pkg and srl_in_if.
module srl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  srl_in_if.sink              in_bus,
  output srl_pkg::mem_req_t   mem_req,
  input  srl_pkg::rec_t       mem_rdata,
  output logic                res_valid,
  output srl_pkg::res_t       res,
  input  logic                res_ready
);

  localparam int AW = srl_pkg::ADDR_W;
  localparam int CW = srl_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [CW-1:0]              issue_r, issue_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  srl_pkg::kind_t             kind_r, kind_nxt;
  logic [srl_pkg::KEY_W-1:0]  key_r, key_nxt;
  srl_pkg::status_t           status_r, status_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;

  logic [srl_pkg::KEY_W-1:0]  key_in;
  logic [CW-1:0]              last_idx;
  logic [CW-1:0]              rd_next;
  logic [CW-1:0]              rd_prev;
  logic [CW-1:0]              fill_inc;
  logic [CW-1:0]              fill_dec;

  assign key_in   = in_bus.rec_key & srl_pkg::KEY_MASK;
  assign last_idx = fill_r - CW'(1);
  assign rd_next  = rd_idx_r + CW'(1);
  assign rd_prev  = rd_idx_r - CW'(1);
  assign fill_inc = fill_r + CW'(1);
  assign fill_dec = fill_r - CW'(1);

  assign in_bus.ready    = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_RESP);
  assign res.status      = status_r;
  assign res.position    = pos_r;
  assign res.entry_total = fill_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    issue_nxt  = issue_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          kind_nxt   = in_bus.kind;
          key_nxt    = key_in;
          status_nxt = srl_pkg::ST_DONE;
          pos_nxt    = '0;
          state_nxt  = S_RESP;
          issue_nxt  = '0;
          unique case (in_bus.kind)
            srl_pkg::KIND_APPEND: begin
              if (fill_r == CW'(srl_pkg::CAPACITY)) begin
                status_nxt = srl_pkg::ST_FULL;
              end else begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = fill_r[AW-1:0];
                mem_req.wdata.key   = key_in;
                mem_req.wdata.name  = in_bus.rec_name;
                mem_req.wdata.score = in_bus.rec_score;
                fill_nxt            = fill_inc;
                pos_nxt             = fill_inc;
              end
            end
            srl_pkg::KIND_DEL_HEAD: begin
              if (fill_r == '0) begin
                status_nxt = srl_pkg::ST_EMPTY;
              end else begin
                pos_nxt = CW'(1);
                if (fill_r == CW'(1)) begin
                  fill_nxt = fill_dec;
                end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = AW'(1);
                  rd_vld_nxt    = 1'b1;
                  rd_idx_nxt    = CW'(1);
                  issue_nxt     = CW'(2);
                  state_nxt     = S_SHIFT;
                end
              end
            end
            srl_pkg::KIND_SEARCH, srl_pkg::KIND_DEL_KEY: begin
              if (fill_r == '0) begin
                status_nxt = (in_bus.kind == srl_pkg::KIND_SEARCH) ?
                             srl_pkg::ST_NOT_FOUND : srl_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_r < fill_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = issue_r[AW-1:0];
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = issue_r;
          issue_nxt     = issue_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (mem_rdata.key == key_r) begin
            pos_nxt    = rd_next;
            status_nxt = srl_pkg::ST_DONE;
            if (kind_r == srl_pkg::KIND_SEARCH || rd_idx_r == last_idx) begin
              if (kind_r == srl_pkg::KIND_DEL_KEY) begin
                fill_nxt = fill_dec;
              end
              mem_req.re = 1'b0;
              rd_vld_nxt = 1'b0;
              state_nxt  = S_RESP;
            end else begin
              // restart the read stream at the entry after the match
              mem_req.re    = 1'b1;
              mem_req.raddr = rd_next[AW-1:0];
              rd_vld_nxt    = 1'b1;
              rd_idx_nxt    = rd_next;
              issue_nxt     = rd_idx_r + CW'(2);
              state_nxt     = S_SHIFT;
            end
          end else if (rd_idx_r == last_idx) begin
            status_nxt = srl_pkg::ST_NOT_FOUND;
            pos_nxt    = '0;
            state_nxt  = S_RESP;
          end
        end
      end

      S_SHIFT: begin
        if (issue_r < fill_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = issue_r[AW-1:0];
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = issue_r;
          issue_nxt     = issue_r + CW'(1);
        end
        if (rd_vld_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rd_prev[AW-1:0];
          mem_req.wdata = mem_rdata;
          if (rd_idx_r == last_idx) begin
            fill_nxt  = fill_dec;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r  <= issue_nxt;
    rd_idx_r <= rd_idx_nxt;
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

endmodule

FILE: rtl/sequential_record_list_unit.sv
// Sequential record list: an ordered table of up to srl_pkg::CAPACITY records
// (key, name, score) kept in one synchronous record memory. One item is worked
// at a time. Append and any command on an empty table need no scan or shift:
// the result goes from the controller's result registers to the output register.
// Search walks the memory one entry per cycle through its single read port and
// answers at the first match, or after the last entry when the key is absent.
// Delete head and delete by key add a shift of every later record down by one,
// one record per cycle. Results leave through an output register, so a waiting
// result does not hold up the current item.
// After reset the table is empty; no clearing pass is needed.
// Depends on srl_pkg, srl_if, srl_ram and srl_ctrl.
module sequential_record_list_unit (
  input  logic        clk,
  input  logic        rst_n,
  srl_in_if.sink      in_bus,
  srl_out_if.source   out_bus
);

  srl_pkg::mem_req_t  mem_req;
  srl_pkg::rec_t      mem_rdata;
  logic               res_valid;
  logic               res_ready;
  srl_pkg::res_t      res;

  logic               out_valid_r;
  srl_pkg::res_t      out_res_r;

  srl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  srl_ram #(
    .WIDTH ($bits(srl_pkg::rec_t)),
    .DEPTH (srl_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_res_r.status;
  assign out_bus.position    = out_res_r.position;
  assign out_bus.entry_total = out_res_r.entry_total;

endmodule

FILE: rtl/srl_checker.sv
// Port-level checks for the sequential record list, bound to the top level.
// Depends on srl_pkg and sequential_record_list_unit.
module srl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input srl_pkg::status_t           out_status,
  input logic [srl_pkg::CNT_W-1:0]  out_position,
  input logic [srl_pkg::CNT_W-1:0]  out_entry_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= srl_pkg::CNT_W'(srl_pkg::CAPACITY)
                  && out_position <= srl_pkg::CNT_W'(srl_pkg::CAPACITY))
    else $error("count or position beyond capacity");

  a_fail_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != srl_pkg::ST_DONE |-> out_position == '0
      && (out_status != srl_pkg::ST_FULL
          || out_entry_total == srl_pkg::CNT_W'(srl_pkg::CAPACITY))
      && (out_status != srl_pkg::ST_EMPTY || out_entry_total == '0))
    else $error("failure status with inconsistent position or count");

  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == srl_pkg::ST_DONE |-> out_position != '0)
    else $error("done status without a position");

endmodule

bind sequential_record_list_unit srl_checker u_srl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_status      (out_bus.status),
  .out_position    (out_bus.position),
  .out_entry_total (out_bus.entry_total)
);
